/* sv/flow_time_machine_dispatcher_unit_macros.svh */
// Assertion macros shared by the dispatcher RTL.
`ifndef FLOW_TIME_MACHINE_DISPATCHER_UNIT_MACROS_SVH
`define FLOW_TIME_MACHINE_DISPATCHER_UNIT_MACROS_SVH

// Same-cycle implication, clocked on aclk and off during reset.
`define FTMD_ASSERT_IMP(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error("ftmd: assertion failed");

// Next-cycle implication, clocked on aclk and off during reset.
`define FTMD_ASSERT_NXT(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("ftmd: assertion failed");

`endif

/* sv/ftmd_pkg.sv */
// Types, widths and constants of the machine dispatcher.
`default_nettype none

package ftmd_pkg;

    localparam int MACHINE_COUNT = 5;
    localparam int FRAC_BITS     = 12;
    localparam int MACH_IDX_W    = (MACHINE_COUNT > 1) ? $clog2(MACHINE_COUNT) : 1;

    localparam int PROC_W      = 16;
    localparam int READY_W     = 24;
    localparam int READY_Q_W   = READY_W + FRAC_BITS;
    localparam int FACTOR_W    = 16;
    localparam int WORK_W      = PROC_W + FACTOR_W;
    localparam int FINISH_W    = 48;
    localparam int FLOW_W      = 56;
    localparam int MACH_OUT_W  = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_IDX_W-1:0]  REG_MEDIAN    = 3'd5;
    localparam logic [FACTOR_W-1:0]   FACTOR_RESET  = FACTOR_W'(1 << FRAC_BITS);
    localparam logic [PROC_W:0]       STRICT_MARGIN = (PROC_W + 1)'(2);
    localparam logic [FINISH_W-1:0]   FINISH_MAX    = '1;
    localparam logic [FLOW_W-1:0]     FLOW_MAX      = '1;

    typedef struct packed {
        logic [PROC_W-1:0]  processing_time;
        logic [READY_W-1:0] ready_time;
    } in_item_t;

    typedef struct packed {
        logic [MACH_OUT_W-1:0] chosen_machine;
        logic [FINISH_W-1:0]   finish_time;
        logic [FLOW_W-1:0]     machine_flow_sum;
        logic [FLOW_W-1:0]     total_flow_sum;
    } out_item_t;

    // The task under work, held for the whole scan.
    typedef struct packed {
        logic [PROC_W-1:0]    proc;
        logic [READY_Q_W-1:0] ready_q;
    } job_t;

    typedef struct packed {
        logic                  valid;
        logic [MACH_IDX_W-1:0] idx;
    } issue_t;

    typedef struct packed {
        logic                  valid;
        logic [MACH_IDX_W-1:0] idx;
        logic [FINISH_W-1:0]   fin;
        logic [FLOW_W-1:0]     flow;
        logic [FLOW_W-1:0]     inc;
    } trial_t;

    typedef struct packed {
        logic [MACH_IDX_W-1:0] idx;
        logic [FINISH_W-1:0]   fin;
        logic [FLOW_W-1:0]     flow;
        logic [FLOW_W-1:0]     inc;
    } best_t;

endpackage

`default_nettype wire

/* sv/ftmd_trial.sv */
// Shared three-stage unit that works out one machine's trial finish and flow.
`default_nettype none

module ftmd_trial
    import ftmd_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire issue_t              issue,
    input  wire job_t                job,
    input  wire logic [FACTOR_W-1:0] factor,
    input  wire logic [FINISH_W-1:0] finish,
    input  wire logic [FLOW_W-1:0]   flow,
    output trial_t                   result
);

    logic                  s1_valid_reg;
    logic [MACH_IDX_W-1:0] s1_idx_reg;
    logic [WORK_W-1:0]     s1_work_reg;
    logic [FINISH_W-1:0]   s1_start_reg;
    logic [FLOW_W-1:0]     s1_flow_reg;

    logic                  s2_valid_reg;
    logic [MACH_IDX_W-1:0] s2_idx_reg;
    logic [FINISH_W-1:0]   s2_fin_reg;
    logic [FINISH_W-1:0]   s2_diff_reg;
    logic [FLOW_W-1:0]     s2_flow_reg;

    trial_t                result_reg;

    logic [FINISH_W-1:0]   ready_ext;
    logic [FINISH_W-1:0]   start_next;
    logic [FINISH_W:0]     fin_sum;
    logic [FINISH_W-1:0]   fin_next;
    logic [FLOW_W:0]       flow_sum;
    logic                  flow_ovf;

    assign ready_ext  = FINISH_W'(job.ready_q);
    assign start_next = (finish > ready_ext) ? finish : ready_ext;

    assign fin_sum  = {1'b0, s1_start_reg} + (FINISH_W + 1)'(s1_work_reg);
    assign fin_next = fin_sum[FINISH_W] ? FINISH_MAX : fin_sum[FINISH_W-1:0];

    assign flow_sum = {1'b0, s2_flow_reg} + (FLOW_W + 1)'(s2_diff_reg);
    assign flow_ovf = flow_sum[FLOW_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            result_reg.valid <= 1'b0;
        end else begin
            s1_valid_reg     <= issue.valid;
            s2_valid_reg     <= s1_valid_reg;
            result_reg.valid <= s2_valid_reg;
        end

        s1_idx_reg   <= issue.idx;
        s1_work_reg  <= WORK_W'(job.proc) * WORK_W'(factor);
        s1_start_reg <= start_next;
        s1_flow_reg  <= flow;

        s2_idx_reg  <= s1_idx_reg;
        s2_fin_reg  <= fin_next;
        s2_diff_reg <= fin_next - ready_ext;
        s2_flow_reg <= s1_flow_reg;

        result_reg.idx  <= s2_idx_reg;
        result_reg.fin  <= s2_fin_reg;
        result_reg.flow <= flow_ovf ? FLOW_MAX : flow_sum[FLOW_W-1:0];
        // On saturation the flow sum only grows up to its ceiling.
        result_reg.inc  <= flow_ovf ? ~s2_flow_reg : FLOW_W'(s2_diff_reg);
    end

    assign result = result_reg;

endmodule

`default_nettype wire

/* sv/ftmd_ctrl.sv */
// Sequencer: takes a task, issues the machines in turn and keeps the best one.
`default_nettype none

module ftmd_ctrl
    import ftmd_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire in_item_t          s_data,
    input  wire logic [PROC_W-1:0] median,
    input  wire trial_t            result,
    input  wire logic              out_free,
    output issue_t                 issue,
    output job_t                   job,
    output best_t                  best,
    output logic                   commit
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_WRITE
    } state_t;

    localparam logic [MACH_IDX_W-1:0] LAST_IDX  = MACH_IDX_W'(MACHINE_COUNT - 1);
    localparam logic [MACH_IDX_W-1:0] FIRST_IDX = '0;

    state_t                state_reg, state_next;
    logic [MACH_IDX_W-1:0] cnt_reg, cnt_next;
    job_t                  job_reg, job_next;
    logic                  strict_reg, strict_next;
    best_t                 best_reg, best_next;

    logic lower_flow;
    logic lower_fin;
    logic wins;

    assign lower_flow = result.flow < best_reg.flow;
    assign lower_fin  = result.fin < best_reg.fin;
    assign wins       = strict_reg ? (lower_flow && lower_fin) : (lower_flow || lower_fin);

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        job_next    = job_reg;
        strict_next = strict_reg;
        best_next   = best_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    job_next.proc    = s_data.processing_time;
                    job_next.ready_q = {s_data.ready_time, {FRAC_BITS{1'b0}}};
                    strict_next      = ({1'b0, s_data.processing_time} + STRICT_MARGIN)
                                       >= {1'b0, median};
                    cnt_next         = FIRST_IDX;
                    state_next       = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_IDX) begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (result.valid && result.idx == LAST_IDX) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Machine 0 always seeds the holder; later machines replace it on a win.
        if (result.valid && (result.idx == FIRST_IDX || wins)) begin
            best_next.idx  = result.idx;
            best_next.fin  = result.fin;
            best_next.flow = result.flow;
            best_next.inc  = result.inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= FIRST_IDX;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
        job_reg    <= job_next;
        strict_reg <= strict_next;
        best_reg   <= best_next;
    end

    assign s_ready     = (state_reg == ST_IDLE);
    assign issue.valid = (state_reg == ST_ISSUE);
    assign issue.idx   = cnt_reg;
    assign job         = job_reg;
    assign best        = best_reg;
    assign commit      = (state_reg == ST_WRITE) && out_free;

endmodule

`default_nettype wire

/* sv/flow_time_machine_dispatcher_unit.sv */
// Top level of the machine dispatcher: registers, machine state and result stage.
//
//  channel   direction  handshake             payload
//  s_        in         s_valid / s_ready     in_item_t  (processing_time, ready_time)
//  m_        out        m_valid / m_ready     out_item_t (machine, finish, flows)
//  cfg_      in         cfg_wr_en             cfg_index, cfg_wdata
//
// Each task is accepted, then each machine is issued in turn into the shared
// three-stage trial unit; once that unit has drained, the chosen result is
// written back.
// Reset is synchronous and clears the machine state, the total flow and the registers.
// A new task is taken while an earlier result still waits on m_ready; write-back
// stalls only if that earlier result is still not taken.
`default_nettype none
`include "flow_time_machine_dispatcher_unit_macros.svh"

module flow_time_machine_dispatcher_unit
    import ftmd_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_item_t              s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_item_t                  m_data,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic [FACTOR_W-1:0] factor_reg [MACHINE_COUNT];
    logic [PROC_W-1:0]   median_reg;
    logic [FINISH_W-1:0] finish_reg [MACHINE_COUNT];
    logic [FLOW_W-1:0]   flow_reg   [MACHINE_COUNT];
    logic [FLOW_W-1:0]   total_reg, total_next;
    out_item_t           out_reg;
    logic                m_valid_reg;

    issue_t     issue;
    job_t       job;
    best_t      best;
    trial_t     result;
    logic       commit;
    logic       out_free;
    logic [FLOW_W:0] total_sum;

    assign out_free   = !m_valid_reg || m_ready;
    assign total_sum  = {1'b0, total_reg} + {1'b0, best.inc};
    assign total_next = total_sum[FLOW_W] ? FLOW_MAX : total_sum[FLOW_W-1:0];

    ftmd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .median   (median_reg),
        .result   (result),
        .out_free (out_free),
        .issue    (issue),
        .job      (job),
        .best     (best),
        .commit   (commit)
    );

    ftmd_trial u_trial (
        .aclk    (aclk),
        .aresetn (aresetn),
        .issue   (issue),
        .job     (job),
        .factor  (factor_reg[issue.idx]),
        .finish  (finish_reg[issue.idx]),
        .flow    (flow_reg[issue.idx]),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MACHINE_COUNT; i++) begin
                factor_reg[i] <= FACTOR_RESET;
                finish_reg[i] <= '0;
                flow_reg[i]   <= '0;
            end
            median_reg  <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                for (int i = 0; i < MACHINE_COUNT; i++) begin
                    if (cfg_index == CFG_IDX_W'(i)) begin
                        factor_reg[i] <= cfg_wdata;
                    end
                end
                if (cfg_index == REG_MEDIAN) begin
                    median_reg <= cfg_wdata;
                end
            end
            if (commit) begin
                for (int i = 0; i < MACHINE_COUNT; i++) begin
                    if (best.idx == MACH_IDX_W'(i)) begin
                        finish_reg[i] <= best.fin;
                        flow_reg[i]   <= best.flow;
                    end
                end
                total_reg   <= total_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            out_reg.chosen_machine   <= MACH_OUT_W'(best.idx);
            out_reg.finish_time      <= best.fin;
            out_reg.machine_flow_sum <= best.flow;
            out_reg.total_flow_sum   <= total_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    `FTMD_ASSERT_NXT(a_busy_after_accept, s_valid && s_ready, !s_ready)
    `FTMD_ASSERT_IMP(a_commit_needs_room, commit, out_free)
    `FTMD_ASSERT_IMP(a_machine_in_range, m_valid,
                     m_data.chosen_machine < MACH_OUT_W'(MACHINE_COUNT))
    `FTMD_ASSERT_IMP(a_total_covers_machine, m_valid,
                     m_data.total_flow_sum >= m_data.machine_flow_sum)

endmodule

`default_nettype wire

/* test/ftmd_dispatch_checker.sv */
`timescale 1ns / 100ps
// Checker that predicts each machine assignment and compares it with the result channel.
module ftmd_dispatch_checker
    import ftmd_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    input  wire logic                  s_ready,
    input  wire in_item_t              s_data,
    input  wire logic                  m_valid,
    input  wire logic                  m_ready,
    input  wire out_item_t             m_data,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                         mismatch_count,
    output int                         assignments_due,
    output int                         assignments_checked
);

    logic [FACTOR_W-1:0] speed_q    [MACHINE_COUNT];
    logic [PROC_W-1:0]   median_q;
    logic [FINISH_W-1:0] busy_until [MACHINE_COUNT];
    logic [FLOW_W-1:0]   flow_acc   [MACHINE_COUNT];
    logic [FLOW_W-1:0]   flow_grand;
    out_item_t           due_q [$];
    int                  errors  = 0;
    int                  checked = 0;

    // Scans the machines in index order and commits the chosen one's trial values.
    function automatic out_item_t dispatch_task(input in_item_t t);
        logic [63:0]   ready_fx, start, fin, flow, best_fin, best_flow, total;
        logic [PROC_W:0] proc_ext;
        logic          strict, lower_flow, lower_fin, wins;
        int            m, best;
        out_item_t     r;
        ready_fx  = 64'(t.ready_time) << FRAC_BITS;
        proc_ext  = t.processing_time;
        strict    = (proc_ext + STRICT_MARGIN) >= {1'b0, median_q};
        best      = 0;
        best_fin  = '0;
        best_flow = '0;
        for (m = 0; m < MACHINE_COUNT; m++) begin
            start = (64'(busy_until[m]) > ready_fx) ? 64'(busy_until[m]) : ready_fx;
            fin   = start + 64'(t.processing_time) * 64'(speed_q[m]);
            if (fin > 64'(FINISH_MAX))
                fin = 64'(FINISH_MAX);
            flow = 64'(flow_acc[m]) + (fin - ready_fx);
            if (flow > 64'(FLOW_MAX))
                flow = 64'(FLOW_MAX);
            if (m == 0) begin
                best_fin  = fin;
                best_flow = flow;
            end else begin
                lower_flow = flow < best_flow;
                lower_fin  = fin < best_fin;
                wins = strict ? (lower_flow && lower_fin) : (lower_flow || lower_fin);
                if (wins) begin
                    best      = m;
                    best_fin  = fin;
                    best_flow = flow;
                end
            end
        end
        // The grand total grows by what the chosen machine's sum actually gained.
        total = 64'(flow_grand) + (best_flow - 64'(flow_acc[best]));
        if (total > 64'(FLOW_MAX))
            total = 64'(FLOW_MAX);
        busy_until[best] = best_fin[FINISH_W-1:0];
        flow_acc[best]   = best_flow[FLOW_W-1:0];
        flow_grand       = total[FLOW_W-1:0];
        r.chosen_machine   = MACH_OUT_W'(best);
        r.finish_time      = best_fin[FINISH_W-1:0];
        r.machine_flow_sum = best_flow[FLOW_W-1:0];
        r.total_flow_sum   = total[FLOW_W-1:0];
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        out_item_t want;
        int        m;
        if (!aresetn) begin
            for (m = 0; m < MACHINE_COUNT; m++) begin
                speed_q[m]    = FACTOR_RESET;
                busy_until[m] = '0;
                flow_acc[m]   = '0;
            end
            median_q   = '0;
            flow_grand = '0;
            due_q.delete();
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index < CFG_IDX_W'(MACHINE_COUNT))
                    speed_q[cfg_index] = cfg_wdata;
                else if (cfg_index == REG_MEDIAN)
                    median_q = cfg_wdata;
            end
            if (m_valid && m_ready) begin
                if (due_q.size() == 0) begin
                    $error("result transfer with no assignment pending: machine %0d",
                           m_data.chosen_machine);
                    errors++;
                end else begin
                    want = due_q.pop_front();
                    checked++;
                    if (m_data.chosen_machine !== want.chosen_machine) begin
                        $error("chosen_machine: expected %0d, got %0d",
                               want.chosen_machine, m_data.chosen_machine);
                        errors++;
                    end
                    if (m_data.finish_time !== want.finish_time) begin
                        $error("finish_time: expected %0d, got %0d",
                               want.finish_time, m_data.finish_time);
                        errors++;
                    end
                    if (m_data.machine_flow_sum !== want.machine_flow_sum) begin
                        $error("machine_flow_sum: expected %0d, got %0d",
                               want.machine_flow_sum, m_data.machine_flow_sum);
                        errors++;
                    end
                    if (m_data.total_flow_sum !== want.total_flow_sum) begin
                        $error("total_flow_sum: expected %0d, got %0d",
                               want.total_flow_sum, m_data.total_flow_sum);
                        errors++;
                    end
                end
            end
            if (s_valid && s_ready)
                due_q.insert(due_q.size(), dispatch_task(s_data));
        end
        mismatch_count      <= errors;
        assignments_due     <= due_q.size();
        assignments_checked <= checked;
    end

endmodule

/* test/tb_flow_time_machine_dispatcher_unit.sv */
`timescale 1ns / 100ps
// Top of the dispatcher testbench: clock, reset, register setup, task stimulus and verdict.
module tb_flow_time_machine_dispatcher_unit;
    import ftmd_pkg::*;

    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 300;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_item_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_item_t             m_data;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int mismatch_count;
    int assignments_due;
    int assignments_checked;

    int                 send_idle_pct  = 0;
    int                 recv_stall_pct = 0;
    int                 settings_used  = 0;
    bit                 hold_request   = 1'b0;
    logic [READY_W-1:0] clock_cursor   = '0;
    logic [PROC_W-1:0]  median_now     = '0;

    flow_time_machine_dispatcher_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    ftmd_dispatch_checker u_checker (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_data              (s_data),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_data              (m_data),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_index           (cfg_index),
        .cfg_wdata           (cfg_wdata),
        .mismatch_count      (mismatch_count),
        .assignments_due     (assignments_due),
        .assignments_checked (assignments_checked)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off when asked for.
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    task automatic send_task(input in_item_t t);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= t;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (assignments_due != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Writes all eight register slots; the two above the median register are unused.
    task automatic program_regs(input logic [FACTOR_W-1:0] f0, f1, f2, f3, f4,
                                input logic [PROC_W-1:0] med);
        logic [FACTOR_W-1:0] fac [MACHINE_COUNT];
        int                  i;
        fac = '{f0, f1, f2, f3, f4};
        for (i = 0; i < (1 << CFG_IDX_W); i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            if (i < MACHINE_COUNT)
                cfg_wdata <= fac[i];
            else if (CFG_IDX_W'(i) == REG_MEDIAN)
                cfg_wdata <= med;
            else
                cfg_wdata <= CFG_DATA_W'($urandom);
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        median_now = med;
        settings_used++;
    endtask

    function automatic logic [FACTOR_W-1:0] random_factor();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            return FACTOR_W'($urandom_range(1024, 16384));
        if (pick < 9)
            return FACTOR_W'($urandom_range(1, 65535));
        return ($urandom_range(0, 1) != 0) ? {FACTOR_W{1'b1}} : FACTOR_W'(1);
    endfunction

    // Most tasks arrive around a slowly advancing clock so that machines
    // stay partly busy; the rest jump anywhere in the field.
    function automatic in_item_t random_task();
        in_item_t t;
        int       pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            t.processing_time = PROC_W'($urandom_range(0, 400));
        else if (pick < 75)
            t.processing_time = median_now + PROC_W'(1) - PROC_W'($urandom_range(0, 4));
        else if (pick < 95)
            t.processing_time = PROC_W'($urandom);
        else
            t.processing_time = {PROC_W{pick[0]}};
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            clock_cursor = clock_cursor + READY_W'($urandom_range(0, 40));
            t.ready_time = clock_cursor - READY_W'($urandom_range(0, 60));
        end else if (pick < 94) begin
            t.ready_time = READY_W'($urandom);
        end else begin
            t.ready_time = {READY_W{pick[0]}};
        end
        return t;
    endfunction

    task automatic run_phase(input int count, input int s_idle, input int r_stall);
        send_idle_pct  = s_idle;
        recv_stall_pct = r_stall;
        repeat (count) send_task(random_task());
        drain();
    endtask

    initial begin
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: unit speed everywhere and a zero median, so the strict
        // rule applies and equal trials stay on the lower machine.
        send_task('{16'h0000, 24'h000000});
        send_task('{16'h0000, 24'h000000});
        send_task('{16'hFFFF, 24'hFFFFFF});
        send_task('{16'hFFFF, 24'h000000});
        send_task('{16'h0000, 24'hFFFFFF});
        send_task('{16'h0001, 24'h000000});
        send_task('{16'h0001, 24'h000000});
        send_task('{16'h0001, 24'h000000});
        drain();

        // A zero speed factor and both ends of the factor range.
        program_regs(16'h0000, 16'h0001, 16'hFFFF, 16'h1000, 16'h0800, 16'h0000);
        send_task('{16'hFFFF, 24'h000000});
        send_task('{16'hFFFF, 24'h000000});
        send_task('{16'h0064, 24'h000005});
        send_task('{16'h0000, 24'h000000});
        send_task('{16'hFFFF, 24'hFFFFFF});
        drain();

        // Largest median: only the top three processing times take the strict rule.
        program_regs(16'h1000, 16'h1000, 16'h1000, 16'h1000, 16'h1000, 16'hFFFF);
        send_task('{16'hFFFC, 24'h00000A});
        send_task('{16'hFFFD, 24'h00000A});
        send_task('{16'hFFFF, 24'h00000A});
        send_task('{16'h0000, 24'h00000A});
        send_task('{16'h000A, 24'h00000A});
        send_task('{16'h000A, 24'h00000A});
        drain();

        // A median of one still forces the strict rule on every task.
        program_regs(16'h1000, 16'h2000, 16'h0800, 16'h1000, 16'h3000, 16'h0001);
        send_task('{16'h0000, 24'h000000});
        send_task('{16'h0001, 24'h000003});
        drain();

        program_regs(random_factor(), random_factor(), random_factor(), random_factor(),
                     random_factor(), 16'd100);
        run_phase(220, 0, 0);
        program_regs(random_factor(), random_factor(), random_factor(), random_factor(),
                     random_factor(), 16'd1);
        run_phase(200, 84, 0);
        program_regs(16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF, 16'd500);
        run_phase(200, 0, 84);
        program_regs(random_factor(), random_factor(), random_factor(), random_factor(),
                     random_factor(), 16'hFFFF);
        run_phase(200, 34, 34);

        // The result side holds off while tasks keep coming, so the input backs up.
        program_regs(random_factor(), random_factor(), random_factor(), random_factor(),
                     random_factor(), 16'd300);
        hold_request = 1'b1;
        run_phase(80, 0, 0);

        program_regs(random_factor(), random_factor(), random_factor(), random_factor(),
                     random_factor(), PROC_W'($urandom));
        run_phase(300, 34, 34);

        $display("Dispatched and checked %0d tasks under %0d register settings,", 
                 assignments_checked, settings_used);
        $display("with four idle mixes and one long stall on the result side.");
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* flow_time_machine_dispatcher_unit.f */
+incdir+sv
sv/ftmd_pkg.sv
sv/ftmd_trial.sv
sv/ftmd_ctrl.sv
sv/flow_time_machine_dispatcher_unit.sv
test/ftmd_dispatch_checker.sv
test/tb_flow_time_machine_dispatcher_unit.sv
